/* rtl/core/next_permutation_engine_assert.svh */
// Assertion macros for the next permutation engine checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef NEXT_PERMUTATION_ENGINE_ASSERT_SVH
`define NEXT_PERMUTATION_ENGINE_ASSERT_SVH

// A property checked at every rising edge outside reset.
`define NPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define NPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  `NPE_ASSERT(lbl, (ante) |=> (cons), msg)

// A condition that must never be seen.
`define NPE_ASSERT_NEVER(lbl, cond, msg) \
  `NPE_ASSERT(lbl, !(cond), msg)

`endif

/* rtl/core/npe_pkg.sv */
package npe_pkg;

  localparam int MAX_LEN    = 16;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
  localparam int TUSER_W = 2;

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  // Operand pair for the shared comparator.
  typedef struct packed {
    val_t lhs;
    val_t rhs;
  } cmp_req_t;

endpackage

/* rtl/core/next_permutation_engine.sv */
// Next permutation engine: load takes one element per cycle; input ready only in the load phase.
// After the last element: pivot scan from the right end, successor scan, swap, suffix
// reversal pair by pair, then emit one result per beat. With no pivot the whole run is
// reversed; a single element goes straight to emit.
// Reset (rst_n low, synchronous) empties the store count, clears the overflow mark,
// drops any result in flight and returns the engine to the load phase.
module next_permutation_engine
  import npe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Input stream, one element per beat.
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [VALUE_BITS-1:0] element_value
  input  logic               in_tlast,   // element_last
  // Result stream, one element of the next permutation per beat.
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [VALUE_BITS-1:0] result_value
  output logic               out_tlast,  // result_last
  output logic [TUSER_W-1:0] out_tuser   // [0] wrapped, [1] overflowed
);

  // Sequencer states. Every step that needs a stored element issues a read
  // in one state and uses the registered read data in the next.
  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_PV_FIRST = 4'd1;
  localparam logic [3:0] S_PV_HOLD  = 4'd2;
  localparam logic [3:0] S_PV_RD    = 4'd3;
  localparam logic [3:0] S_PV_CMP   = 4'd4;
  localparam logic [3:0] S_SC_RD    = 4'd5;
  localparam logic [3:0] S_SC_CMP   = 4'd6;
  localparam logic [3:0] S_SW_P     = 4'd7;
  localparam logic [3:0] S_SW_S     = 4'd8;
  localparam logic [3:0] S_RV_RDA   = 4'd9;
  localparam logic [3:0] S_RV_RDB   = 4'd10;
  localparam logic [3:0] S_RV_WA    = 4'd11;
  localparam logic [3:0] S_RV_WB    = 4'd12;
  localparam logic [3:0] S_EM_RD    = 4'd13;
  localparam logic [3:0] S_EM_LD    = 4'd14;
  localparam logic [3:0] S_EM_WT    = 4'd15;

  logic [3:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;       // number of stored elements
  logic       ovf_r, ovf_nxt;       // an element was dropped in this load
  logic       wrap_r, wrap_nxt;     // no pivot was found
  idx_t       idx_r, idx_nxt;       // scan index, successor index, upper end, emit index
  idx_t       piv_r, piv_nxt;       // pivot index, then lower end of the reversal
  val_t       hold_r, hold_nxt;     // element held between reads
  val_t       pval_r, pval_nxt;     // pivot value
  val_t       out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Store port signals.
  logic       ram_we;
  idx_t       ram_waddr;
  val_t       ram_wdata;
  idx_t       ram_raddr;
  val_t       ram_rdata;

  // Shared comparator.
  cmp_req_t   cmp_req;
  logic       cmp_less;

  logic       in_beat;
  logic       room;
  cnt_t       load_n;
  idx_t       load_last_idx;
  idx_t       last_idx;

  npe_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  npe_cmp u_cmp (
    .req  (cmp_req),
    .less (cmp_less)
  );

  assign in_tready  = (state_r == S_LOAD);
  assign in_beat    = in_tvalid && in_tready;
  assign room       = (cnt_r < CNT_W'(MAX_LEN));

  // Count after the current beat, and the index of the final stored element.
  assign load_n        = room ? (cnt_r + CNT_W'(1)) : cnt_r;
  assign load_last_idx = IDX_W'(load_n - CNT_W'(1));
  assign last_idx      = IDX_W'(cnt_r - CNT_W'(1));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'($unsigned(out_data_r));
  assign out_tlast  = out_last_r;
  assign out_tuser  = {ovf_r, wrap_r};

  // The pivot scan asks whether the left element is below the one to its
  // right; the successor scan asks whether the pivot is below a candidate.
  always_comb begin
    if (state_r == S_PV_CMP) begin
      cmp_req.lhs = ram_rdata;
      cmp_req.rhs = hold_r;
    end else begin
      cmp_req.lhs = pval_r;
      cmp_req.rhs = ram_rdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    wrap_nxt      = wrap_r;
    idx_nxt       = idx_r;
    piv_nxt       = piv_r;
    hold_nxt      = hold_r;
    pval_nxt      = pval_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = piv_r;
    ram_wdata     = hold_r;
    ram_raddr     = idx_r;

    case (state_r)
      S_LOAD: begin
        ram_waddr = IDX_W'(cnt_r);
        ram_wdata = in_tdata[VALUE_BITS-1:0];
        if (in_beat) begin
          // Elements beyond the capacity are dropped but still noted.
          if (room) begin
            ram_we  = 1'b1;
            cnt_nxt = load_n;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            if (load_n < CNT_W'(2)) begin
              // A single element has no pivot and stays as it is.
              wrap_nxt  = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_EM_RD;
            end else begin
              wrap_nxt  = 1'b0;
              idx_nxt   = load_last_idx;
              state_nxt = S_PV_FIRST;
            end
          end
        end
      end
      S_PV_FIRST: begin
        state_nxt = S_PV_HOLD;
      end
      S_PV_HOLD: begin
        hold_nxt  = ram_rdata;
        idx_nxt   = idx_r - IDX_W'(1);
        state_nxt = S_PV_RD;
      end
      S_PV_RD: begin
        state_nxt = S_PV_CMP;
      end
      S_PV_CMP: begin
        if (cmp_less) begin
          piv_nxt   = idx_r;
          pval_nxt  = ram_rdata;
          idx_nxt   = last_idx;
          state_nxt = S_SC_RD;
        end else if (idx_r == '0) begin
          // No element is below its right neighbour: reverse the whole run.
          wrap_nxt  = 1'b1;
          piv_nxt   = '0;
          idx_nxt   = last_idx;
          state_nxt = S_RV_RDA;
        end else begin
          hold_nxt  = ram_rdata;
          idx_nxt   = idx_r - IDX_W'(1);
          state_nxt = S_PV_RD;
        end
      end
      S_SC_RD: begin
        state_nxt = S_SC_CMP;
      end
      S_SC_CMP: begin
        // The element right of the pivot is larger, so this scan always ends.
        if (cmp_less) begin
          hold_nxt  = ram_rdata;
          state_nxt = S_SW_P;
        end else begin
          idx_nxt   = idx_r - IDX_W'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_SW_P: begin
        ram_we    = 1'b1;
        ram_waddr = piv_r;
        ram_wdata = hold_r;
        state_nxt = S_SW_S;
      end
      S_SW_S: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = pval_r;
        piv_nxt   = piv_r + IDX_W'(1);
        idx_nxt   = last_idx;
        state_nxt = S_RV_RDA;
      end
      S_RV_RDA: begin
        ram_raddr = piv_r;
        if (piv_r < idx_r) begin
          state_nxt = S_RV_RDB;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_EM_RD;
        end
      end
      S_RV_RDB: begin
        hold_nxt  = ram_rdata;
        state_nxt = S_RV_WA;
      end
      S_RV_WA: begin
        ram_we    = 1'b1;
        ram_waddr = piv_r;
        ram_wdata = ram_rdata;
        state_nxt = S_RV_WB;
      end
      S_RV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = hold_r;
        piv_nxt   = piv_r + IDX_W'(1);
        idx_nxt   = idx_r - IDX_W'(1);
        state_nxt = S_RV_RDA;
      end
      S_EM_RD: begin
        state_nxt = S_EM_LD;
      end
      S_EM_LD: begin
        out_data_nxt  = ram_rdata;
        out_last_nxt  = (idx_r == last_idx);
        out_valid_nxt = 1'b1;
        state_nxt     = S_EM_WT;
      end
      S_EM_WT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      wrap_r      <= wrap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    piv_r      <= piv_nxt;
    hold_r     <= hold_nxt;
    pval_r     <= pval_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

/* rtl/core/npe_ram.sv */
module npe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/npe_cmp.sv */
module npe_cmp
  import npe_pkg::*;
(
  input  cmp_req_t req,
  output logic     less
);

  // Both operands are signed, so this is a two's complement comparison.
  assign less = (req.lhs < req.rhs);

endmodule

/* rtl/core/npe_checker.sv */
`include "next_permutation_engine_assert.svh"

module npe_checker
  import npe_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               in_tlast,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tlast,
  input logic [TUSER_W-1:0] out_tuser
);

  logic in_beat;
  logic out_beat;
  logic mid_run;
  logic out_stall;

  assign in_beat   = in_tvalid && in_tready;
  assign out_beat  = out_tvalid && out_tready;
  assign mid_run   = out_tvalid && !out_tlast;
  assign out_stall = out_tvalid && !out_tready;

  // Loading and emitting never overlap.
  `NPE_ASSERT_NEVER(a_no_overlap, in_tready && out_tvalid, "input ready while a result is shown")

  // The final element of a load closes the input until the results are out.
  `NPE_ASSERT_NEXT(a_load_closes, in_beat && in_tlast, !in_tready, "ready after last element")

  // Once the final result is taken, the engine is ready for the next load.
  `NPE_ASSERT_NEXT(a_reopen, out_beat && out_tlast, in_tready, "not ready after final result")

  // The flags are the same on every result of one run.
  `NPE_ASSERT_NEXT(a_flags_hold, mid_run, $stable(out_tuser), "flags changed within a run")

  // A result that is not taken stays unchanged.
  `NPE_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "stalled beat changed")

endmodule

bind next_permutation_engine npe_checker u_npe_checker (.*);
